>>> rtl/core/hmm_scaled_backward_step_unit_defines.svh
// Assertion macros shared by the backward step unit.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef HMM_SCALED_BACKWARD_STEP_UNIT_DEFINES_SVH
`define HMM_SCALED_BACKWARD_STEP_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HSBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define HSBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/hsbs_pkg.sv
// Shared types and constants of the scaled HMM backward step unit.
// Depends on nothing.
package hsbs_pkg;

    localparam int OPC_W   = 2;
    localparam int IDX_W   = 4;
    localparam int PROB_W  = 17;
    localparam int SCALE_W = 32;
    localparam int TIME_W  = 16;
    localparam int BETA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int AE_W    = 18;
    localparam int PROD_W  = AE_W + BETA_W;

    localparam logic [OPC_W-1:0] OP_LOAD_T = 2'd0;
    localparam logic [OPC_W-1:0] OP_LOAD_E = 2'd1;
    localparam logic [OPC_W-1:0] OP_START  = 2'd2;
    localparam logic [OPC_W-1:0] OP_STEP   = 2'd3;

    localparam logic [BETA_W-1:0] BETA_ONE = 32'h0001_0000;
    localparam logic [15:0]       Q16_HALF = 16'h8000;

    typedef struct packed {
        logic cap_item;
        logic tbl_wr_t;
        logic tbl_wr_e;
        logic set_one;
        logic acc_clear;
        logic mac_issue;
        logic mac_last;
        logic scale_s;
        logic scale_lo;
        logic scale_hi;
        logic scale_fin;
        logic out_load;
        logic out_one;
        logic out_last;
        logic beta_wr;
        logic bank_flip;
    } hsbs_cmd_t;

    typedef struct packed {
        logic out_free;
        logic mac_done;
    } hsbs_stat_t;

endpackage

>>> rtl/core/hsbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module hsbs_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/hsbs_ctrl.sv
// Sequencer of the backward step unit: item decode, row and column counters, result pacing.
// Depends on hsbs_pkg.
module hsbs_ctrl
    import hsbs_pkg::*;
#(
    parameter int NUM_STATES = 16,
    parameter int CW         = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [OPC_W-1:0] opcode,
    input  hsbs_stat_t       stat,
    output hsbs_cmd_t        cmd,
    output logic [CW-1:0]    row_sel,
    output logic [CW-1:0]    col_sel
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ONE_OUT = 4'd1;
    localparam logic [3:0] S_MAC     = 4'd2;
    localparam logic [3:0] S_DRAIN   = 4'd3;
    localparam logic [3:0] S_SC_S    = 4'd4;
    localparam logic [3:0] S_SC_LO   = 4'd5;
    localparam logic [3:0] S_SC_HI   = 4'd6;
    localparam logic [3:0] S_SC_FIN  = 4'd7;
    localparam logic [3:0] S_OUT     = 4'd8;

    localparam logic [CW-1:0] LAST_IDX = CW'(NUM_STATES - 1);

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic          row_last, col_last;

    assign row_last = (row_reg == LAST_IDX);
    assign col_last = (col_reg == LAST_IDX);
    assign in_ready = (state_reg == S_IDLE);
    assign row_sel  = row_reg;
    assign col_sel  = col_reg;

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap_item = 1'b1;
                    case (opcode)
                        OP_LOAD_T: cmd.tbl_wr_t = 1'b1;
                        OP_LOAD_E: cmd.tbl_wr_e = 1'b1;
                        OP_START:
                        begin
                            cmd.set_one = 1'b1;
                            row_next    = '0;
                            state_next  = S_ONE_OUT;
                        end
                        OP_STEP:
                        begin
                            cmd.acc_clear = 1'b1;
                            row_next      = '0;
                            col_next      = '0;
                            state_next    = S_MAC;
                        end
                        default: ;
                    endcase
                end
            end
            S_ONE_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_one  = 1'b1;
                    cmd.out_last = row_last;
                    if (row_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
            end
            S_MAC:
            begin
                cmd.mac_issue = 1'b1;
                cmd.mac_last  = col_last;
                if (col_last)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (stat.mac_done)
                begin
                    state_next = S_SC_S;
                end
            end
            S_SC_S:
            begin
                cmd.scale_s = 1'b1;
                state_next  = S_SC_LO;
            end
            S_SC_LO:
            begin
                cmd.scale_lo = 1'b1;
                state_next   = S_SC_HI;
            end
            S_SC_HI:
            begin
                cmd.scale_hi = 1'b1;
                state_next   = S_SC_FIN;
            end
            S_SC_FIN:
            begin
                cmd.scale_fin = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_last  = row_last;
                    cmd.beta_wr   = 1'b1;
                    cmd.acc_clear = 1'b1;
                    if (row_last)
                    begin
                        cmd.bank_flip = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        col_next   = '0;
                        state_next = S_MAC;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

endmodule

>>> rtl/core/hsbs_dp.sv
// Datapath of the backward step unit: table and beta memories, MAC pipeline,
// rounding, scaling with saturation and the result register.
// Depends on hsbs_pkg and hsbs_ram.
module hsbs_dp
    import hsbs_pkg::*;
#(
    parameter int NUM_STATES  = 16,
    parameter int NUM_SYMBOLS = 16,
    parameter int CW          = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hsbs_cmd_t          cmd,
    output hsbs_stat_t         stat,
    input  logic [CW-1:0]      row_sel,
    input  logic [CW-1:0]      col_sel,
    input  logic [IDX_W-1:0]   row_index,
    input  logic [IDX_W-1:0]   col_index,
    input  logic [IDX_W-1:0]   symbol,
    input  logic [PROB_W-1:0]  probability,
    input  logic [SCALE_W-1:0] scale,
    input  logic [TIME_W-1:0]  time_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [TIME_W-1:0]  time_index_out,
    output logic [IDX_W-1:0]   state_index,
    output logic [BETA_W-1:0]  beta_value,
    output logic               last
);

    localparam int TA_DEPTH = NUM_STATES * NUM_STATES;
    localparam int TA_AW    = (TA_DEPTH > 1) ? $clog2(TA_DEPTH) : 1;
    localparam int EM_DEPTH = NUM_STATES * NUM_SYMBOLS;
    localparam int EM_AW    = (EM_DEPTH > 1) ? $clog2(EM_DEPTH) : 1;
    localparam int BA_DEPTH = 2 * NUM_STATES;
    localparam int BA_AW    = $clog2(BA_DEPTH);
    localparam int ACC_W    = PROD_W + CW;
    localparam int S_W      = ACC_W - FRAC_W + 1;
    localparam int SP_W     = S_W + 16;
    localparam int V_W      = SP_W + 1;
    localparam int AEP_W    = 2 * PROB_W;

    // Item fields held for the duration of a step.
    logic [IDX_W-1:0]   sym_reg;
    logic               sym_ok_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [TIME_W-1:0]  time_reg;

    logic               one_reg;
    logic               bank_reg;

    logic               t_ok, e_ok;
    logic [TA_AW-1:0]   t_waddr, t_raddr;
    logic [EM_AW-1:0]   e_waddr, e_raddr;
    logic [BA_AW-1:0]   b_waddr, b_raddr;
    logic [PROB_W-1:0]  t_rdata, e_rdata, e_use;
    logic [BETA_W-1:0]  b_rdata;
    logic [IDX_W-1:0]   e_sym;

    logic               p1_valid_reg, p1_last_reg;
    logic               p2_valid_reg, p2_last_reg;
    logic               p3_valid_reg, p3_last_reg;
    logic               mac_done_reg;
    logic [AEP_W-1:0]   ae_prod;
    logic [AE_W-1:0]    ae_reg;
    logic [BETA_W-1:0]  beta_d_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [ACC_W-1:0]   acc_reg;

    logic [ACC_W:0]     s_sum;
    logic [S_W-1:0]     s_reg;
    logic [15:0]        mul_b;
    logic [SP_W-1:0]    mul_res;
    logic [SP_W-1:0]    pl_reg, ph_reg;
    logic [V_W-1:0]     v_sum;
    logic [BETA_W-1:0]  beta_new_reg;

    logic               out_valid_reg;
    logic [TIME_W-1:0]  time_out_reg;
    logic [IDX_W-1:0]   state_out_reg;
    logic [BETA_W-1:0]  beta_out_reg;
    logic               last_out_reg;

    assign t_ok    = (int'(row_index) < NUM_STATES) && (int'(col_index) < NUM_STATES);
    assign e_ok    = (int'(row_index) < NUM_STATES) && (int'(symbol) < NUM_SYMBOLS);
    assign t_waddr = TA_AW'(int'(row_index) * NUM_STATES + int'(col_index));
    assign e_waddr = EM_AW'(int'(row_index) * NUM_SYMBOLS + int'(symbol));
    assign t_raddr = TA_AW'(int'(row_sel) * NUM_STATES + int'(col_sel));
    assign e_sym   = sym_ok_reg ? sym_reg : '0;
    assign e_raddr = EM_AW'(int'(col_sel) * NUM_SYMBOLS + int'(e_sym));
    // The current beta row lives in one half of the memory, the new row is written to the other.
    assign b_raddr = bank_reg ? BA_AW'(NUM_STATES + int'(col_sel)) : BA_AW'(col_sel);
    assign b_waddr = bank_reg ? BA_AW'(row_sel) : BA_AW'(NUM_STATES + int'(row_sel));

    hsbs_ram #(
        .WIDTH  (PROB_W),
        .DEPTH  (TA_DEPTH),
        .ADDR_W (TA_AW)
    ) u_trans_ram (
        .clk   (clk),
        .we    (cmd.tbl_wr_t && t_ok),
        .waddr (t_waddr),
        .wdata (probability),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    hsbs_ram #(
        .WIDTH  (PROB_W),
        .DEPTH  (EM_DEPTH),
        .ADDR_W (EM_AW)
    ) u_emis_ram (
        .clk   (clk),
        .we    (cmd.tbl_wr_e && e_ok),
        .waddr (e_waddr),
        .wdata (probability),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    hsbs_ram #(
        .WIDTH  (BETA_W),
        .DEPTH  (BA_DEPTH),
        .ADDR_W (BA_AW)
    ) u_beta_ram (
        .clk   (clk),
        .we    (cmd.beta_wr),
        .waddr (b_waddr),
        .wdata (beta_new_reg),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    assign e_use   = sym_ok_reg ? e_rdata : '0;
    assign ae_prod = AEP_W'(t_rdata) * AEP_W'(e_use);
    assign s_sum   = {1'b0, acc_reg} + (ACC_W + 1)'(Q16_HALF);
    assign mul_b   = cmd.scale_hi ? scale_reg[31:16] : scale_reg[15:0];
    assign mul_res = SP_W'(s_reg) * SP_W'(mul_b);
    assign v_sum   = V_W'(ph_reg) + ((V_W'(pl_reg) + V_W'(Q16_HALF)) >> FRAC_W);

    always_ff @(posedge clk)
    begin
        if (cmd.cap_item)
        begin
            sym_reg    <= symbol;
            sym_ok_reg <= (int'(symbol) < NUM_SYMBOLS);
            scale_reg  <= scale;
            time_reg   <= time_index;
        end
        if (p1_valid_reg)
        begin
            ae_reg     <= AE_W'((ae_prod + AEP_W'(Q16_HALF)) >> FRAC_W);
            beta_d_reg <= one_reg ? BETA_ONE : b_rdata;
        end
        if (p2_valid_reg)
        begin
            prod_reg <= PROD_W'(ae_reg) * PROD_W'(beta_d_reg);
        end
        if (cmd.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (p3_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.scale_s)
        begin
            s_reg <= S_W'(s_sum >> FRAC_W);
        end
        if (cmd.scale_lo)
        begin
            pl_reg <= mul_res;
        end
        if (cmd.scale_hi)
        begin
            ph_reg <= mul_res;
        end
        if (cmd.scale_fin)
        begin
            beta_new_reg <= (|v_sum[V_W-1:BETA_W]) ? '1 : v_sum[BETA_W-1:0];
        end
        if (cmd.out_load)
        begin
            time_out_reg  <= time_reg;
            state_out_reg <= IDX_W'(row_sel);
            beta_out_reg  <= cmd.out_one ? BETA_ONE : beta_new_reg;
            last_out_reg  <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_reg       <= 1'b1;
            bank_reg      <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p1_last_reg   <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p2_last_reg   <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p3_last_reg   <= 1'b0;
            mac_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_one)
            begin
                one_reg <= 1'b1;
            end
            else if (cmd.bank_flip)
            begin
                one_reg <= 1'b0;
            end
            if (cmd.bank_flip)
            begin
                bank_reg <= !bank_reg;
            end
            p1_valid_reg <= cmd.mac_issue;
            p1_last_reg  <= cmd.mac_issue && cmd.mac_last;
            p2_valid_reg <= p1_valid_reg;
            p2_last_reg  <= p1_last_reg;
            p3_valid_reg <= p2_valid_reg;
            p3_last_reg  <= p2_last_reg;
            mac_done_reg <= p3_valid_reg && p3_last_reg;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.mac_done = mac_done_reg;

    assign out_valid      = out_valid_reg;
    assign time_index_out = time_out_reg;
    assign state_index    = state_out_reg;
    assign beta_value     = beta_out_reg;
    assign last           = last_out_reg;

endmodule

>>> rtl/core/hmm_scaled_backward_step_unit.sv
// Top level of the scaled HMM backward step unit.
// Depends on hsbs_pkg, hsbs_ctrl, hsbs_dp and the assertion macro header.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    opcode, row_index, col_index, symbol,
//                                              probability, scale, time_index
//   out      output     out_valid / out_ready  time_index_out, state_index, beta_value, last
//
// A table load leaves the sequencer idle; a start item gives NUM_STATES results, one per cycle while out_ready is held.
// In a step each beta entry runs NUM_STATES passes through the single multiply-accumulate
// pipeline, then rounding and scaling.
// Reset sets the beta row to 1.0; the tables are undefined until loaded.
// A stalled output holds the sequencer before each result transfer; a new item is taken
// while the last result of a row still waits in the output register.
`include "hmm_scaled_backward_step_unit_defines.svh"

module hmm_scaled_backward_step_unit
    import hsbs_pkg::*;
#(
    parameter int NUM_STATES  = 16,
    parameter int NUM_SYMBOLS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OPC_W-1:0]   opcode,
    input  logic [IDX_W-1:0]   row_index,
    input  logic [IDX_W-1:0]   col_index,
    input  logic [IDX_W-1:0]   symbol,
    input  logic [PROB_W-1:0]  probability,
    input  logic [SCALE_W-1:0] scale,
    input  logic [TIME_W-1:0]  time_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [TIME_W-1:0]  time_index_out,
    output logic [IDX_W-1:0]   state_index,
    output logic [BETA_W-1:0]  beta_value,
    output logic               last
);

    localparam int CW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;

    hsbs_cmd_t     cmd;
    hsbs_stat_t    stat;
    logic [CW-1:0] row_sel;
    logic [CW-1:0] col_sel;

    hsbs_ctrl #(
        .NUM_STATES (NUM_STATES),
        .CW         (CW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .stat     (stat),
        .cmd      (cmd),
        .row_sel  (row_sel),
        .col_sel  (col_sel)
    );

    hsbs_dp #(
        .NUM_STATES  (NUM_STATES),
        .NUM_SYMBOLS (NUM_SYMBOLS),
        .CW          (CW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .row_sel        (row_sel),
        .col_sel        (col_sel),
        .row_index      (row_index),
        .col_index      (col_index),
        .symbol         (symbol),
        .probability    (probability),
        .scale          (scale),
        .time_index     (time_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .time_index_out (time_index_out),
        .state_index    (state_index),
        .beta_value     (beta_value),
        .last           (last)
    );

    `HSBS_ASSERT_NEXT(a_load_keeps_ready, in_valid && in_ready && (opcode == OP_LOAD_T || opcode == OP_LOAD_E), in_ready, "Table load did not return to idle")
    `HSBS_ASSERT_NEXT(a_step_busy, in_valid && in_ready && opcode == OP_STEP, !in_ready, "Step transfer did not start the sequencer")
    `HSBS_ASSERT_NEXT(a_start_busy, in_valid && in_ready && opcode == OP_START, !in_ready, "Start transfer did not start the sequencer")
    `HSBS_ASSERT_NOW(a_last_index, out_valid && last, state_index == IDX_W'(NUM_STATES - 1), "Row end marked on the wrong state")

endmodule

>>> bench/hsbs_tb_pkg.sv
// Scoreboard for the scaled HMM backward step unit: it follows the transition and
// emission tables and the beta row, and checks every result row in order.
// Depends on hsbs_pkg.
package hsbs_tb_pkg;
    import hsbs_pkg::*;

    localparam int N_STATES  = 16;
    localparam int N_SYMBOLS = 16;

    typedef struct packed {
        logic [TIME_W-1:0] row_time;
        logic [IDX_W-1:0]  state;
        logic [BETA_W-1:0] beta;
        logic              row_end;
    } beta_entry_t;

    class beta_row_board;
        logic [PROB_W-1:0] trans_tbl [N_STATES][N_STATES];
        logic [PROB_W-1:0] emit_tbl [N_STATES][N_SYMBOLS];
        logic [BETA_W-1:0] beta_row [N_STATES];
        beta_entry_t       expected_betas [$];
        int                errors;

        function new();
            errors = 0;
            for (int i = 0; i < N_STATES; i++)
            begin
                beta_row[i] = BETA_ONE;
                for (int j = 0; j < N_STATES; j++)
                    trans_tbl[i][j] = '0;
                for (int j = 0; j < N_SYMBOLS; j++)
                    emit_tbl[i][j] = '0;
            end
        endfunction

        function int pending();
            return expected_betas.size();
        endfunction

        function void queue_row(input logic [TIME_W-1:0] tim);
            for (int i = 0; i < N_STATES; i++)
                expected_betas.push_back('{tim, IDX_W'(i), beta_row[i],
                                           logic'(i == N_STATES - 1)});
        endfunction

        function void note_transfer(input logic [OPC_W-1:0] op,
                                    input logic [IDX_W-1:0] row,
                                    input logic [IDX_W-1:0] col,
                                    input logic [IDX_W-1:0] sym,
                                    input logic [PROB_W-1:0] prob,
                                    input logic [SCALE_W-1:0] scl,
                                    input logic [TIME_W-1:0] tim);
            logic [63:0]       ae;
            logic [63:0]       acc;
            logic [63:0]       s;
            logic [79:0]       prod;
            logic [BETA_W-1:0] fresh [N_STATES];
            case (op)
                OP_LOAD_T:
                begin
                    if (row < N_STATES && col < N_STATES)
                        trans_tbl[row][col] = prob;
                end
                OP_LOAD_E:
                begin
                    if (row < N_STATES && sym < N_SYMBOLS)
                        emit_tbl[row][sym] = prob;
                end
                OP_START:
                begin
                    for (int i = 0; i < N_STATES; i++)
                        beta_row[i] = BETA_ONE;
                    queue_row(tim);
                end
                OP_STEP:
                begin
                    for (int i = 0; i < N_STATES; i++)
                    begin
                        acc = '0;
                        if (sym < N_SYMBOLS)
                        begin
                            for (int j = 0; j < N_STATES; j++)
                            begin
                                ae = (64'(trans_tbl[i][j]) * 64'(emit_tbl[j][sym])
                                      + 64'(Q16_HALF)) >> 16;
                                acc += ae * 64'(beta_row[j]);
                            end
                        end
                        s = (acc + 64'(Q16_HALF)) >> 16;
                        prod = (80'(s) * 80'(scl) + 80'(Q16_HALF)) >> 16;
                        fresh[i] = (prod > 80'(32'hFFFF_FFFF)) ? '1 : prod[BETA_W-1:0];
                    end
                    for (int i = 0; i < N_STATES; i++)
                        beta_row[i] = fresh[i];
                    queue_row(tim);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_beta(input logic [TIME_W-1:0] tim,
                                 input logic [IDX_W-1:0] state,
                                 input logic [BETA_W-1:0] beta,
                                 input logic row_end);
            beta_entry_t want;
            if (expected_betas.size() == 0)
            begin
                $display("%0t: result with none expected: time %0h state %0d beta %0h last %0b",
                         $time, tim, state, beta, row_end);
                errors++;
                return;
            end
            want = expected_betas.pop_front();
            if (tim !== want.row_time)
            begin
                $display("%0t: time_index_out expected %0h actual %0h",
                         $time, want.row_time, tim);
                errors++;
            end
            if (state !== want.state)
            begin
                $display("%0t: state_index expected %0d actual %0d", $time, want.state, state);
                errors++;
            end
            if (beta !== want.beta)
            begin
                $display("%0t: beta_value of state %0d expected %0h actual %0h",
                         $time, want.state, want.beta, beta);
                errors++;
            end
            if (row_end !== want.row_end)
            begin
                $display("%0t: last of state %0d expected %0b actual %0b",
                         $time, want.state, want.row_end, row_end);
                errors++;
            end
        endfunction
    endclass
endpackage

>>> bench/tb_top.sv
// Top of the testbench for the scaled HMM backward step unit: it fills the tables,
// runs directed and random beta sequences with random stalls on both channels.
// Depends on hsbs_pkg, hsbs_tb_pkg and the RTL of the unit.
module tb_top;
    import hsbs_pkg::*;
    import hsbs_tb_pkg::*;

    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 600;
    localparam int RANDOM_ITEMS = 320;
    localparam int QUIET_FROM   = 280;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [OPC_W-1:0]   opcode;
    logic [IDX_W-1:0]   row_index;
    logic [IDX_W-1:0]   col_index;
    logic [IDX_W-1:0]   symbol;
    logic [PROB_W-1:0]  probability;
    logic [SCALE_W-1:0] scale;
    logic [TIME_W-1:0]  time_index;
    logic               out_valid;
    logic               out_ready;
    logic [TIME_W-1:0]  time_index_out;
    logic [IDX_W-1:0]   state_index;
    logic [BETA_W-1:0]  beta_value;
    logic               last;

    bit            quiet = 1'b0;
    int            idle_cycles = 0;
    beta_row_board board;

    hmm_scaled_backward_step_unit #(
        .NUM_STATES  (N_STATES),
        .NUM_SYMBOLS (N_SYMBOLS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .row_index      (row_index),
        .col_index      (col_index),
        .symbol         (symbol),
        .probability    (probability),
        .scale          (scale),
        .time_index     (time_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .time_index_out (time_index_out),
        .state_index    (state_index),
        .beta_value     (beta_value),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            if (quiet)
            begin
                out_ready = 1'b1;
                @(negedge clk);
            end
            else
            begin
                out_ready = 1'b1;
                repeat ($urandom_range(1, ($urandom_range(0, 5) == 0) ? 150 : 20))
                    @(negedge clk);
                out_ready = 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            board.note_transfer(opcode, row_index, col_index, symbol, probability, scale,
                                time_index);
        if (rst_n && out_valid && out_ready)
            board.check_beta(time_index_out, state_index, beta_value, last);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[hmm_scaled_backward_step_unit] ERROR");
            $finish;
        end
    end

    function automatic logic [PROB_W-1:0] pick_prob();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return PROB_W'(32'h0001_0000);
            2: return '1;
            3: return PROB_W'($urandom);
            default: return PROB_W'($urandom_range(0, 8192));
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return $urandom;
            default: return SCALE_W'($urandom_range(32'h4000, 32'h4_0000));
        endcase
    endfunction

    task automatic issue_item(input logic [OPC_W-1:0] op, input logic [IDX_W-1:0] row,
                              input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] sym,
                              input logic [PROB_W-1:0] prob, input logic [SCALE_W-1:0] scl,
                              input logic [TIME_W-1:0] tim);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_valid    = 1'b1;
        opcode      = op;
        row_index   = row;
        col_index   = col;
        symbol      = sym;
        probability = prob;
        scale       = scl;
        time_index  = tim;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic load_transition(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                                   input logic [PROB_W-1:0] prob);
        issue_item(OP_LOAD_T, row, col, IDX_W'($urandom), prob, $urandom, TIME_W'($urandom));
    endtask

    task automatic load_emission(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] sym,
                                 input logic [PROB_W-1:0] prob);
        issue_item(OP_LOAD_E, row, IDX_W'($urandom), sym, prob, $urandom, TIME_W'($urandom));
    endtask

    task automatic start_row(input logic [TIME_W-1:0] tim);
        issue_item(OP_START, IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                   PROB_W'($urandom), $urandom, tim);
    endtask

    task automatic step_back(input logic [IDX_W-1:0] sym, input logic [SCALE_W-1:0] scl,
                             input logic [TIME_W-1:0] tim);
        issue_item(OP_STEP, IDX_W'($urandom), IDX_W'($urandom), sym, PROB_W'($urandom),
                   scl, tim);
    endtask

    task automatic wait_drained();
        while (board.pending() != 0) @(posedge clk);
    endtask

    initial
    begin
        int               sent;
        int               steps;
        logic [TIME_W-1:0] t_now;
        board       = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        opcode      = OP_LOAD_T;
        row_index   = '0;
        col_index   = '0;
        symbol      = '0;
        probability = '0;
        scale       = '0;
        time_index  = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Every table entry is written before the first step reads it.
        for (int r = 0; r < N_STATES; r++)
            for (int c = 0; c < N_STATES; c++)
                load_transition(IDX_W'(r), IDX_W'(c), PROB_W'($urandom_range(0, 8192)));
        for (int r = 0; r < N_STATES; r++)
            for (int s = 0; s < N_SYMBOLS; s++)
                load_emission(IDX_W'(r), IDX_W'(s), PROB_W'($urandom_range(0, 65536)));

        step_back(4'd3, 32'h0001_0000, 16'd100);
        start_row(16'hFFFF);
        load_transition(4'd0, 4'd0, '1);
        load_transition(4'd15, 4'd15, '0);
        load_emission(4'd0, 4'd15, '1);
        load_emission(4'd15, 4'd0, PROB_W'(32'h0001_0000));
        load_emission(4'd0, 4'd0, '1);
        step_back(4'd15, 32'hFFFF_FFFF, 16'hFFFF);
        step_back(4'd0, 32'h0001_0000, 16'hFFFE);
        step_back(4'd0, 32'h0000_0000, 16'h0000);
        step_back(4'd7, 32'hFFFF_FFFF, 16'h0001);
        start_row(16'h0000);
        step_back(4'd15, 32'h0000_0001, 16'h8000);
        start_row(16'h5A5A);
        step_back(4'd9, 32'h0001_0000, 16'hA5A5);
        step_back(4'd12, 32'h0002_8000, 16'h1234);

        wait_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= QUIET_FROM)
                quiet = 1'b1;
            if ($urandom_range(0, 9) < 7)
            begin
                t_now = TIME_W'($urandom);
                start_row(t_now);
                sent++;
                steps = $urandom_range(1, 6);
                for (int k = 0; k < steps; k++)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        if ($urandom_range(0, 1) == 0)
                            load_transition(IDX_W'($urandom), IDX_W'($urandom), pick_prob());
                        else
                            load_emission(IDX_W'($urandom), IDX_W'($urandom), pick_prob());
                        sent++;
                    end
                    t_now = t_now - 1'b1;
                    step_back(IDX_W'($urandom), pick_scale(), t_now);
                    sent++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    issue_item(OPC_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                               IDX_W'($urandom), pick_prob(), $urandom, TIME_W'($urandom));
                    sent++;
                end
            end
        end
        in_valid = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("[hmm_scaled_backward_step_unit] OK");
        else
            $display("[hmm_scaled_backward_step_unit] ERROR");
        $finish;
    end
endmodule
